### rtl/fmd_pkg.sv
// ----------------------------------------------------------------------------
// fmd_pkg
// Shared constants, types and helpers of the FM I/Q discriminator.
// ----------------------------------------------------------------------------
package fmd_pkg;

    localparam int PAIRS_PER_SAMPLE  = 8;
    localparam int ANGLES_PER_OUTPUT = 8;
    localparam int ANGLE_FRAC_BITS   = 16;

    localparam int ACC_W      = 8 + $clog2(PAIRS_PER_SAMPLE);
    // sum of two products can reach +2^(2*ACC_W-1), one bit above a single product
    localparam int XY_W       = 2 * ACC_W + 1;
    localparam int QUO_W      = ANGLE_FRAC_BITS + 1;
    localparam int SUM_W      = ANGLE_FRAC_BITS + 2 + $clog2(ANGLES_PER_OUTPUT);
    localparam int PAIR_CNT_W = (PAIRS_PER_SAMPLE > 1) ? $clog2(PAIRS_PER_SAMPLE) : 1;
    localparam int ANG_CNT_W  = (ANGLES_PER_OUTPUT > 1) ? $clog2(ANGLES_PER_OUTPUT) : 1;
    localparam int DIV_CNT_W  = $clog2(QUO_W);
    localparam int MUL_W      = 32;
    localparam int PROD_W     = 2 * MUL_W;
    localparam int ADDR_W     = 3;

    localparam logic signed [MUL_W-1:0] COEF_K1  = 32'sd341782638;
    localparam logic signed [MUL_W-1:0] COEF_K3  = -32'sd111975772;
    localparam logic signed [MUL_W-1:0] COEF_K5  = 32'sd54450835;
    localparam logic signed [MUL_W-1:0] COEF_K7  = -32'sd15891687;
    localparam logic signed [MUL_W-1:0] Q30_ONE  = 32'sd1073741824;
    localparam logic signed [MUL_W-1:0] Q30_HALF = 32'sd536870912;

    localparam logic [15:0] VOLUME_RESET = 16'd4096;
    localparam logic [0:0]  REG_VOLUME   = 1'b0;

    typedef enum logic [4:0] {
        ST_IDLE, ST_XY1, ST_XY2, ST_XY3, ST_XY4, ST_XY5, ST_ABS, ST_DIV,
        ST_SQ, ST_SQR, ST_M1, ST_A1, ST_M2, ST_A2, ST_M3, ST_A3, ST_M4, ST_A4,
        ST_M5, ST_A5, ST_FOLD, ST_ACC, ST_AUDM, ST_OUT
    } fmd_state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_PAIR, OP_XY1, OP_XY2, OP_XY3, OP_XY4, OP_XY5, OP_ABS, OP_DIV,
        OP_SQ, OP_SQR, OP_M1, OP_A1, OP_M2, OP_A2, OP_M3, OP_A3, OP_M4, OP_A4,
        OP_M5, OP_A5, OP_FOLD, OP_ACC, OP_AUDM, OP_OUT
    } fmd_op_t;

    typedef struct packed {
        fmd_op_t op;
        logic    last_pair;
    } fmd_cmd_t;

    typedef struct packed {
        logic out_free;
    } fmd_status_t;

    // divide by 2^sh, truncating toward zero
    function automatic logic signed [PROD_W-1:0] div_pow2(
        input logic signed [PROD_W-1:0] v,
        input int                       sh
    );
        logic signed [PROD_W-1:0] bias;
        logic signed [PROD_W-1:0] t;
        bias = (PROD_W'(1) <<< sh) - PROD_W'(1);
        t    = v + (v[PROD_W-1] ? bias : '0);
        return t >>> sh;
    endfunction

endpackage

### rtl/fmd_ctrl.sv
// ----------------------------------------------------------------------------
// fmd_ctrl
// Sequencer: counts pairs and angles and steps the datapath through one angle.
// ----------------------------------------------------------------------------
module fmd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  fmd_pkg::fmd_status_t status,
    output fmd_pkg::fmd_cmd_t    cmd
);

    fmd_pkg::fmd_state_t                  state_reg, state_next;
    logic [fmd_pkg::PAIR_CNT_W-1:0]       pair_cnt_reg, pair_cnt_next;
    logic [fmd_pkg::ANG_CNT_W-1:0]        ang_cnt_reg, ang_cnt_next;
    logic [fmd_pkg::DIV_CNT_W-1:0]        div_cnt_reg, div_cnt_next;
    logic                                 last_pair;
    logic                                 last_angle;
    logic                                 last_div;

    assign last_pair  = pair_cnt_reg == fmd_pkg::PAIR_CNT_W'(fmd_pkg::PAIRS_PER_SAMPLE - 1);
    assign last_angle = ang_cnt_reg == fmd_pkg::ANG_CNT_W'(fmd_pkg::ANGLES_PER_OUTPUT - 1);
    assign last_div   = div_cnt_reg == fmd_pkg::DIV_CNT_W'(fmd_pkg::QUO_W - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= fmd_pkg::ST_IDLE;
            pair_cnt_reg <= '0;
            ang_cnt_reg  <= '0;
            div_cnt_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            pair_cnt_reg <= pair_cnt_next;
            ang_cnt_reg  <= ang_cnt_next;
            div_cnt_reg  <= div_cnt_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        pair_cnt_next = pair_cnt_reg;
        ang_cnt_next  = ang_cnt_reg;
        div_cnt_next  = div_cnt_reg;
        cmd.op        = fmd_pkg::OP_NONE;
        cmd.last_pair = last_pair;
        s_ready       = 1'b0;
        unique case (state_reg)
            fmd_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op = fmd_pkg::OP_PAIR;
                    if (last_pair) begin
                        pair_cnt_next = '0;
                        state_next    = fmd_pkg::ST_XY1;
                    end else begin
                        pair_cnt_next = pair_cnt_reg + 1'b1;
                    end
                end
            end
            fmd_pkg::ST_XY1: begin cmd.op = fmd_pkg::OP_XY1; state_next = fmd_pkg::ST_XY2; end
            fmd_pkg::ST_XY2: begin cmd.op = fmd_pkg::OP_XY2; state_next = fmd_pkg::ST_XY3; end
            fmd_pkg::ST_XY3: begin cmd.op = fmd_pkg::OP_XY3; state_next = fmd_pkg::ST_XY4; end
            fmd_pkg::ST_XY4: begin cmd.op = fmd_pkg::OP_XY4; state_next = fmd_pkg::ST_XY5; end
            fmd_pkg::ST_XY5: begin cmd.op = fmd_pkg::OP_XY5; state_next = fmd_pkg::ST_ABS; end
            fmd_pkg::ST_ABS: begin
                cmd.op       = fmd_pkg::OP_ABS;
                div_cnt_next = '0;
                state_next   = fmd_pkg::ST_DIV;
            end
            fmd_pkg::ST_DIV: begin
                cmd.op = fmd_pkg::OP_DIV;
                if (last_div) begin
                    state_next = fmd_pkg::ST_SQ;
                end else begin
                    div_cnt_next = div_cnt_reg + 1'b1;
                end
            end
            fmd_pkg::ST_SQ:   begin cmd.op = fmd_pkg::OP_SQ;   state_next = fmd_pkg::ST_SQR;  end
            fmd_pkg::ST_SQR:  begin cmd.op = fmd_pkg::OP_SQR;  state_next = fmd_pkg::ST_M1;   end
            fmd_pkg::ST_M1:   begin cmd.op = fmd_pkg::OP_M1;   state_next = fmd_pkg::ST_A1;   end
            fmd_pkg::ST_A1:   begin cmd.op = fmd_pkg::OP_A1;   state_next = fmd_pkg::ST_M2;   end
            fmd_pkg::ST_M2:   begin cmd.op = fmd_pkg::OP_M2;   state_next = fmd_pkg::ST_A2;   end
            fmd_pkg::ST_A2:   begin cmd.op = fmd_pkg::OP_A2;   state_next = fmd_pkg::ST_M3;   end
            fmd_pkg::ST_M3:   begin cmd.op = fmd_pkg::OP_M3;   state_next = fmd_pkg::ST_A3;   end
            fmd_pkg::ST_A3:   begin cmd.op = fmd_pkg::OP_A3;   state_next = fmd_pkg::ST_M4;   end
            fmd_pkg::ST_M4:   begin cmd.op = fmd_pkg::OP_M4;   state_next = fmd_pkg::ST_A4;   end
            fmd_pkg::ST_A4:   begin cmd.op = fmd_pkg::OP_A4;   state_next = fmd_pkg::ST_M5;   end
            fmd_pkg::ST_M5:   begin cmd.op = fmd_pkg::OP_M5;   state_next = fmd_pkg::ST_A5;   end
            fmd_pkg::ST_A5:   begin cmd.op = fmd_pkg::OP_A5;   state_next = fmd_pkg::ST_FOLD; end
            fmd_pkg::ST_FOLD: begin cmd.op = fmd_pkg::OP_FOLD; state_next = fmd_pkg::ST_ACC;  end
            fmd_pkg::ST_ACC: begin
                cmd.op = fmd_pkg::OP_ACC;
                if (last_angle) begin
                    ang_cnt_next = '0;
                    state_next   = fmd_pkg::ST_AUDM;
                end else begin
                    ang_cnt_next = ang_cnt_reg + 1'b1;
                    state_next   = fmd_pkg::ST_IDLE;
                end
            end
            fmd_pkg::ST_AUDM: begin cmd.op = fmd_pkg::OP_AUDM; state_next = fmd_pkg::ST_OUT; end
            fmd_pkg::ST_OUT: begin
                // hold until the output register is free
                if (status.out_free) begin
                    cmd.op     = fmd_pkg::OP_OUT;
                    state_next = fmd_pkg::ST_IDLE;
                end
            end
            default: state_next = fmd_pkg::ST_IDLE;
        endcase
    end

    a_pair_starts_angle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmd_pkg::ST_IDLE && s_valid && last_pair)
        |=> (state_reg == fmd_pkg::ST_XY1 && pair_cnt_reg == '0))
        else $error("last pair did not start the angle sequence");

    a_div_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmd_pkg::ST_DIV && last_div) |=> state_reg == fmd_pkg::ST_SQ)
        else $error("divider did not finish after all quotient bits");

    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != fmd_pkg::ST_IDLE) |-> !s_ready)
        else $error("input taken while an angle is in progress");

    a_acc_return: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == fmd_pkg::ST_ACC && !last_angle) |=> state_reg == fmd_pkg::ST_IDLE)
        else $error("angle accumulate did not return to idle");

endmodule

### rtl/fmd_dp.sv
// ----------------------------------------------------------------------------
// fmd_dp
// Datapath: pair sums, conjugate product, radix-2 divider, arctangent
// polynomial on a shared multiplier, angle sum and output register.
// ----------------------------------------------------------------------------
module fmd_dp (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  fmd_pkg::fmd_cmd_t         cmd,
    output fmd_pkg::fmd_status_t      status,
    input  logic [7:0]                s_i_sample,
    input  logic [7:0]                s_q_sample,
    input  logic [15:0]               volume,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic signed [15:0]        m_audio_sample
);

    localparam int F = fmd_pkg::ANGLE_FRAC_BITS;
    localparam int XW = fmd_pkg::XY_W;
    localparam int MW = fmd_pkg::MUL_W;
    localparam int PW = fmd_pkg::PROD_W;

    logic signed [fmd_pkg::ACC_W-1:0] i_acc_reg, q_acc_reg;
    logic signed [fmd_pkg::ACC_W-1:0] cur_i_reg, cur_q_reg;
    logic signed [fmd_pkg::ACC_W-1:0] prev_i_reg, prev_q_reg;
    logic signed [XW-1:0]             t_reg, x_reg, y_reg;
    logic [XW-1:0]                    mx_reg;
    logic [XW:0]                      rem_reg;
    logic [fmd_pkg::QUO_W-1:0]        quo_reg;
    logic                             x_neg_reg, y_neg_reg, swap_reg, zero_reg;
    logic signed [PW-1:0]             prod_reg;
    logic signed [MW-1:0]             dq_reg, s_reg, p_reg, a_reg;
    logic signed [fmd_pkg::SUM_W-1:0] angle_sum_reg;
    logic                             m_valid_reg;
    logic signed [15:0]               audio_reg;

    logic signed [8:0]                i_ctr, q_ctr;
    logic signed [fmd_pkg::ACC_W-1:0] i_sum, q_sum;
    logic signed [MW-1:0]             mul_a, mul_b;
    logic signed [PW-1:0]             mul_p;
    logic signed [PW-1:0]             prod_q30;
    logic signed [XW-1:0]             x_new;
    logic [XW-1:0]                    ax, ay;
    logic                             rem_ge;
    logic [XW:0]                      rem_sub;
    logic signed [MW-1:0]             dq_new;
    logic signed [MW-1:0]             f1, f2, f3;
    logic signed [PW-1:0]             angle;
    logic signed [PW-1:0]             audio_full;
    logic signed [15:0]               audio_sat;

    assign i_ctr = $signed({1'b0, s_i_sample}) - 9'sd128;
    assign q_ctr = $signed({1'b0, s_q_sample}) - 9'sd128;
    assign i_sum = i_acc_reg + fmd_pkg::ACC_W'(i_ctr);
    assign q_sum = q_acc_reg + fmd_pkg::ACC_W'(q_ctr);

    assign prod_q30 = fmd_pkg::div_pow2(prod_reg, 30);
    assign x_new    = t_reg + prod_reg[XW-1:0];
    assign ax       = x_reg[XW-1] ? XW'(-x_reg) : x_reg;
    assign ay       = y_reg[XW-1] ? XW'(-y_reg) : y_reg;
    assign rem_ge   = rem_reg >= {1'b0, mx_reg};
    assign rem_sub  = rem_ge ? (rem_reg - {1'b0, mx_reg}) : rem_reg;
    assign dq_new   = MW'(quo_reg) <<< (30 - F);

    // octant unfold
    assign f1 = swap_reg  ? (fmd_pkg::Q30_HALF - a_reg) : a_reg;
    assign f2 = x_neg_reg ? (fmd_pkg::Q30_ONE - f1) : f1;
    assign f3 = zero_reg ? '0 : (y_neg_reg ? -f2 : f2);
    assign angle = fmd_pkg::div_pow2(PW'(a_reg), 30 - F);

    assign audio_full = fmd_pkg::div_pow2(prod_reg, F);
    always_comb begin
        if (audio_full > 64'sd32767) begin
            audio_sat = 16'sh7fff;
        end else if (audio_full < -64'sd32768) begin
            audio_sat = -16'sd32768;
        end else begin
            audio_sat = audio_full[15:0];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            fmd_pkg::OP_XY1: begin mul_a = MW'(prev_i_reg); mul_b = MW'(cur_q_reg); end
            fmd_pkg::OP_XY2: begin mul_a = MW'(prev_q_reg); mul_b = MW'(cur_i_reg); end
            fmd_pkg::OP_XY3: begin mul_a = MW'(prev_i_reg); mul_b = MW'(cur_i_reg); end
            fmd_pkg::OP_XY4: begin mul_a = MW'(prev_q_reg); mul_b = MW'(cur_q_reg); end
            fmd_pkg::OP_SQ:  begin mul_a = dq_new;          mul_b = dq_new;         end
            fmd_pkg::OP_M1:  begin mul_a = fmd_pkg::COEF_K7; mul_b = s_reg;         end
            fmd_pkg::OP_M2:  begin mul_a = p_reg;           mul_b = s_reg;          end
            fmd_pkg::OP_M3:  begin mul_a = p_reg;           mul_b = dq_reg;         end
            fmd_pkg::OP_M4:  begin mul_a = p_reg;           mul_b = s_reg;          end
            fmd_pkg::OP_M5:  begin mul_a = fmd_pkg::COEF_K1; mul_b = dq_reg;        end
            fmd_pkg::OP_AUDM: begin
                mul_a = MW'(angle_sum_reg);
                mul_b = MW'({1'b0, volume});
            end
            default: begin mul_a = '0; mul_b = '0; end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            i_acc_reg     <= '0;
            q_acc_reg     <= '0;
            prev_i_reg    <= '0;
            prev_q_reg    <= '0;
            angle_sum_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cmd.op == fmd_pkg::OP_OUT) begin
                m_valid_reg <= 1'b1;
            end else if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                fmd_pkg::OP_PAIR: begin
                    if (cmd.last_pair) begin
                        cur_i_reg <= i_sum;
                        cur_q_reg <= q_sum;
                        i_acc_reg <= '0;
                        q_acc_reg <= '0;
                    end else begin
                        i_acc_reg <= i_sum;
                        q_acc_reg <= q_sum;
                    end
                end
                fmd_pkg::OP_XY1: prod_reg <= mul_p;
                fmd_pkg::OP_XY2: begin
                    t_reg    <= prod_reg[XW-1:0];
                    prod_reg <= mul_p;
                end
                fmd_pkg::OP_XY3: begin
                    y_reg    <= t_reg - prod_reg[XW-1:0];
                    prod_reg <= mul_p;
                end
                fmd_pkg::OP_XY4: begin
                    t_reg    <= prod_reg[XW-1:0];
                    prod_reg <= mul_p;
                end
                fmd_pkg::OP_XY5: begin
                    x_reg      <= x_new;
                    prev_i_reg <= cur_i_reg;
                    prev_q_reg <= cur_q_reg;
                end
                fmd_pkg::OP_ABS: begin
                    x_neg_reg <= x_reg[XW-1];
                    y_neg_reg <= y_reg[XW-1];
                    swap_reg  <= ay > ax;
                    mx_reg    <= (ay > ax) ? ay : ax;
                    rem_reg   <= {1'b0, ((ay > ax) ? ax : ay)};
                    zero_reg  <= (ax == '0) && (ay == '0);
                    quo_reg   <= '0;
                end
                fmd_pkg::OP_DIV: begin
                    quo_reg <= {quo_reg[fmd_pkg::QUO_W-2:0], rem_ge};
                    rem_reg <= {rem_sub[XW-1:0], 1'b0};
                end
                fmd_pkg::OP_SQ: begin
                    dq_reg   <= dq_new;
                    prod_reg <= mul_p;
                end
                fmd_pkg::OP_SQR: s_reg <= prod_reg[30 +: MW];
                fmd_pkg::OP_M1:  prod_reg <= mul_p;
                fmd_pkg::OP_A1:  p_reg <= MW'(prod_q30) + fmd_pkg::COEF_K5;
                fmd_pkg::OP_M2:  prod_reg <= mul_p;
                fmd_pkg::OP_A2:  p_reg <= MW'(prod_q30) + fmd_pkg::COEF_K3;
                fmd_pkg::OP_M3:  prod_reg <= mul_p;
                fmd_pkg::OP_A3:  p_reg <= MW'(prod_q30);
                fmd_pkg::OP_M4:  prod_reg <= mul_p;
                fmd_pkg::OP_A4:  p_reg <= MW'(prod_q30);
                fmd_pkg::OP_M5:  prod_reg <= mul_p;
                fmd_pkg::OP_A5:  a_reg <= p_reg + MW'(prod_q30);
                fmd_pkg::OP_FOLD: a_reg <= f3;
                fmd_pkg::OP_ACC: angle_sum_reg <= angle_sum_reg + fmd_pkg::SUM_W'(angle);
                fmd_pkg::OP_AUDM: prod_reg <= mul_p;
                fmd_pkg::OP_OUT: begin
                    audio_reg     <= audio_sat;
                    angle_sum_reg <= '0;
                end
                default: ;
            endcase
        end
    end

    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_audio_sample  = audio_reg;

endmodule

### rtl/fm_iq_discriminator_top.sv
// ----------------------------------------------------------------------------
// fm_iq_discriminator_top
// FM quadrature discriminator: decimates I/Q pairs, measures phase step per
// decimated sample, sums angles into scaled 16-bit audio.
//
//   channel  direction  signals
//   s_       in         s_valid, s_ready, s_i_sample, s_q_sample
//   m_       out        m_valid, m_ready, m_audio_sample
//   apb      in/out     psel, penable, pwrite, paddr, pwdata, prdata, pready
//
// pairs are taken while idle; the pair that completes a decimated sample
// is followed by a busy sequence (products, setup, divide, polynomial,
// fold, accumulate) on the shared 32x32 multiplier and radix-2 divider;
// each output adds a volume multiply, and waits while the last result is unread
// s_ready is low while busy; reset is synchronous, volume resets to 4096, counters to zero
// ----------------------------------------------------------------------------
module fm_iq_discriminator_top (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [7:0]                  s_i_sample,
    input  logic [7:0]                  s_q_sample,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic signed [15:0]          m_audio_sample,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fmd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);

    logic [15:0]          volume_reg;
    logic [0:0]           reg_index;
    fmd_pkg::fmd_cmd_t    cmd;
    fmd_pkg::fmd_status_t status;

    assign reg_index = paddr[fmd_pkg::ADDR_W-1:2];
    assign pready    = 1'b1;
    assign prdata    = (reg_index == fmd_pkg::REG_VOLUME) ? {16'd0, volume_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            volume_reg <= fmd_pkg::VOLUME_RESET;
        end else if (psel && penable && pwrite && reg_index == fmd_pkg::REG_VOLUME) begin
            volume_reg <= pwdata[15:0];
        end
    end

    fmd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fmd_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .status         (status),
        .s_i_sample     (s_i_sample),
        .s_q_sample     (s_q_sample),
        .volume         (volume_reg),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_audio_sample (m_audio_sample)
    );

endmodule

### sim/fm_iq_discriminator_top_tb.sv
// ----------------------------------------------------------------------------
// fm_iq_discriminator_top_tb
// Drives I/Q pairs and volume writes into the discriminator, predicts each
// audio sample with an independent fixed-point model and checks every result
// in order, under random idling on both channels and long output back-pressure.
// ----------------------------------------------------------------------------
module fm_iq_discriminator_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint HT_ONE = 64'sd1073741824;
    localparam longint HT_K1  = 64'sd341782638;
    localparam longint HT_K3  = -64'sd111975772;
    localparam longint HT_K5  = 64'sd54450835;
    localparam longint HT_K7  = -64'sd15891687;
    localparam int     SETTLE_CYCLES = 60;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [7:0]                  s_i_sample = '0;
    logic [7:0]                  s_q_sample = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [15:0]          m_audio_sample;
    logic                        psel = 1'b0;
    logic                        penable = 1'b0;
    logic                        pwrite = 1'b0;
    logic [fmd_pkg::ADDR_W-1:0]  paddr = '0;
    logic [31:0]                 pwdata = '0;
    logic [31:0]                 prdata;
    logic                        pready;

    // predictor state
    longint              gain;
    longint              acc_i, acc_q, last_i, last_q, phase_acc;
    int                  pairs_seen, angles_seen;
    logic signed [15:0]  audio_expected[$];

    int                  mismatches = 0;
    int                  audio_seen = 0;
    bit                  idle_on = 1'b1;
    int                  hold_off = 0;

    fm_iq_discriminator_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_i_sample(s_i_sample), .s_q_sample(s_q_sample),
        .m_valid(m_valid), .m_ready(m_ready), .m_audio_sample(m_audio_sample),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // phase step in half-turns, ANGLE_FRAC_BITS fraction bits
    function automatic longint phase_step(longint x, longint y);
        longint ax, ay, mx, mn, d, dq, s, p, a;
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        mx = (ax > ay) ? ax : ay;
        mn = (ax > ay) ? ay : ax;
        if (mx == 0) return 0;
        d  = (mn << fmd_pkg::ANGLE_FRAC_BITS) / mx;
        dq = d * (64'sd1 << (30 - fmd_pkg::ANGLE_FRAC_BITS));
        s  = (dq * dq) / HT_ONE;
        p  = (HT_K7 * s) / HT_ONE + HT_K5;
        p  = (p * s) / HT_ONE + HT_K3;
        p  = (p * dq) / HT_ONE;
        p  = (p * s) / HT_ONE;
        a  = p + (HT_K1 * dq) / HT_ONE;
        if (ay > ax) a = HT_ONE / 2 - a;
        if (x < 0) a = HT_ONE - a;
        if (y < 0) a = -a;
        return a / (64'sd1 << (30 - fmd_pkg::ANGLE_FRAC_BITS));
    endfunction

    function automatic void demod_pair(logic [7:0] iv, logic [7:0] qv);
        longint ni, nq, x, y, au;
        acc_i += longint'(iv) - 128;
        acc_q += longint'(qv) - 128;
        pairs_seen++;
        if (pairs_seen < fmd_pkg::PAIRS_PER_SAMPLE) return;
        ni = acc_i;
        nq = acc_q;
        acc_i = 0;
        acc_q = 0;
        pairs_seen = 0;
        y = last_i * nq - last_q * ni;
        x = last_i * ni + last_q * nq;
        last_i = ni;
        last_q = nq;
        phase_acc += phase_step(x, y);
        angles_seen++;
        if (angles_seen < fmd_pkg::ANGLES_PER_OUTPUT) return;
        au = (phase_acc * gain) / (64'sd1 << fmd_pkg::ANGLE_FRAC_BITS);
        phase_acc = 0;
        angles_seen = 0;
        if (au > 32767) au = 32767;
        if (au < -32768) au = -32768;
        audio_expected.push_back(16'(au));
    endfunction

    // accepted items feed the predictor, accepted results are checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready)
                demod_pair(s_i_sample, s_q_sample);
            if (m_valid && m_ready) begin
                audio_seen++;
                if (audio_expected.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected audio item %0d", m_audio_sample);
                end else begin
                    if (m_audio_sample !== audio_expected[0]) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("audio mismatch: expected %0d actual %0d",
                                     audio_expected[0], m_audio_sample);
                    end
                    void'(audio_expected.pop_front());
                end
            end
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    initial begin
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                repeat (hold_off) @(posedge aclk);
                hold_off = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge aclk);
            end else begin
                m_ready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    task automatic send_pair(input logic [7:0] iv, input logic [7:0] qv);
        s_valid    <= 1'b1;
        s_i_sample <= iv;
        s_q_sample <= qv;
        do @(posedge aclk); while (!s_ready);
        if (idle_on && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
    endtask

    task automatic send_group(input logic [7:0] iv, input logic [7:0] qv);
        repeat (fmd_pkg::PAIRS_PER_SAMPLE) send_pair(iv, qv);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (audio_expected.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_volume(input logic [15:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= fmd_pkg::ADDR_W'(fmd_pkg::REG_VOLUME) << 2;
        pwdata  <= {16'h0, v};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        gain = v;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic test_silence();
        repeat (2 * fmd_pkg::ANGLES_PER_OUTPUT) send_group(8'h80, 8'h80);
    endtask

    // alternating sign on the I axis: every step after the first lands on the negative real axis
    task automatic test_negative_axis();
        repeat (fmd_pkg::ANGLES_PER_OUTPUT) begin
            send_group(8'hff, 8'h80);
            send_group(8'h00, 8'h80);
        end
    endtask

    // clockwise quarter turns, full-scale bytes; saturates at high gain
    task automatic test_quarter_turns();
        repeat (fmd_pkg::ANGLES_PER_OUTPUT) begin
            send_group(8'hff, 8'h80);
            send_group(8'h80, 8'h00);
            send_group(8'h00, 8'h80);
            send_group(8'h80, 8'hff);
        end
    endtask

    task automatic test_random(input int n_items);
        int sent;
        logic [7:0] iv, qv;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(0, 3) != 0) begin
                // steady groups give clean angles
                iv = 8'($urandom);
                qv = 8'($urandom);
                send_group(iv, qv);
                sent += fmd_pkg::PAIRS_PER_SAMPLE;
            end else begin
                send_pair(8'($urandom), 8'($urandom));
                sent++;
            end
        end
    endtask

    // long enough that a second result backs up behind the first
    task automatic test_backpressure();
        hold_off = 2000;
        test_random(200);
    endtask

    initial begin
        gain = fmd_pkg::VOLUME_RESET;
        acc_i = 0; acc_q = 0; last_i = 0; last_q = 0; phase_acc = 0;
        pairs_seen = 0; angles_seen = 0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_silence();
        test_negative_axis();
        test_quarter_turns();
        wait_idle();
        write_volume(16'hffff);
        test_quarter_turns();
        test_negative_axis();
        wait_idle();
        write_volume(16'h0000);
        test_random(128);
        wait_idle();
        write_volume(16'h0001);
        test_random(128);
        wait_idle();
        write_volume(fmd_pkg::VOLUME_RESET);
        test_backpressure();
        wait_idle();
        test_random(300);
        wait_idle();
        write_volume(16'($urandom_range(1, 65535)));
        test_random(200);
        idle_on = 1'b0;
        wait_idle();
        write_volume(16'($urandom_range(8192, 65535)));
        test_random(100);
        wait_idle();

        if (mismatches == 0 && audio_expected.size() == 0)
            $display("[fm_iq_discriminator_top] OK");
        else
            $display("[fm_iq_discriminator_top] ERROR");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("[fm_iq_discriminator_top] ERROR");
        $finish;
    end

endmodule
